[rtl/pich_pkg.sv]
// pich_pkg: shared types, field widths and default sizes for the point in hull test
// no dependencies; imported by pich_datapath, point_in_convex_hull_test, pich_checker and testbench
`default_nettype none

package pich_pkg;

  localparam int DEF_MAX_VERTICES  = 64;
  localparam int DEF_MAX_TRIANGLES = 128;
  localparam int DEF_COORD_BITS    = 16;

  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 7;
  localparam int CORNER_W = 6;
  localparam int COUNT_W  = 8;
  localparam int FACE_W   = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_VERTEX   = 2'd0,
    KIND_TRIANGLE = 2'd1,
    KIND_QUERY    = 2'd2
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // corner index modulo the vertex table depth, by parallel range checks
  function automatic logic [CORNER_W-1:0] corner_reduce(logic [CORNER_W-1:0] v, int m);
    int r;
    int lo;
    r = 0;
    for (int q = 0; q < (1 << CORNER_W); q++) begin
      lo = q * m;
      if ((int'(v) >= lo) && (int'(v) < lo + m)) begin
        r = int'(v) - lo;
      end
    end
    return CORNER_W'(r);
  endfunction

endpackage

`default_nettype wire

[rtl/pich_datapath.sv]
// pich_datapath: pipelined half-space test, sign of dot(p-a, cross(b-a, c-a))
// depends on pich_pkg; five register stages, one triangle per cycle
`default_nettype none

module pich_datapath #(
  parameter int COORD_BITS = pich_pkg::DEF_COORD_BITS,
  parameter int IDX_W      = 7
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    flush,
  input  wire logic                    in_valid,
  input  wire logic [IDX_W-1:0]        in_idx,
  input  wire logic [3*COORD_BITS-1:0] vtx_a,
  input  wire logic [3*COORD_BITS-1:0] vtx_b,
  input  wire logic [3*COORD_BITS-1:0] vtx_c,
  input  wire logic [3*COORD_BITS-1:0] pnt,
  output logic                         out_valid,
  output logic [IDX_W-1:0]             out_idx,
  output logic                         out_face,
  output logic                         active
);
  import pich_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;
  localparam int PW = 2 * C + 2;
  localparam int NW = 2 * C + 3;
  localparam int QW = 3 * C + 4;
  localparam int SW = 3 * C + 6;

  logic signed [DW-1:0] u [3];
  logic signed [DW-1:0] v [3];
  logic signed [DW-1:0] w1 [3];
  logic signed [DW-1:0] w2 [3];
  logic signed [DW-1:0] w3 [3];
  logic signed [PW-1:0] pr [6];
  logic signed [NW-1:0] nrm [3];
  logic signed [QW-1:0] dp [3];
  logic signed [SW-1:0] sum;
  logic                 face;

  logic [4:0]       vld;
  logic [IDX_W-1:0] idx1, idx2, idx3, idx4, idx5;

  // edge vectors and point offset
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      u[k]  <= {vtx_b[k*C+C-1], vtx_b[k*C +: C]} - {vtx_a[k*C+C-1], vtx_a[k*C +: C]};
      v[k]  <= {vtx_c[k*C+C-1], vtx_c[k*C +: C]} - {vtx_a[k*C+C-1], vtx_a[k*C +: C]};
      w1[k] <= {pnt[k*C+C-1], pnt[k*C +: C]} - {vtx_a[k*C+C-1], vtx_a[k*C +: C]};
    end
    idx1 <= in_idx;
  end

  // cross product partial terms
  always_ff @(posedge clk) begin
    pr[0] <= u[1] * v[2];
    pr[1] <= u[2] * v[1];
    pr[2] <= u[2] * v[0];
    pr[3] <= u[0] * v[2];
    pr[4] <= u[0] * v[1];
    pr[5] <= u[1] * v[0];
    w2    <= w1;
    idx2  <= idx1;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      nrm[k] <= {pr[2*k][PW-1], pr[2*k]} - {pr[2*k+1][PW-1], pr[2*k+1]};
    end
    w3   <= w2;
    idx3 <= idx2;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      dp[k] <= w3[k] * nrm[k];
    end
    idx4 <= idx3;
  end

  always_comb begin
    sum = {{2{dp[0][QW-1]}}, dp[0]} + {{2{dp[1][QW-1]}}, dp[1]}
        + {{2{dp[2][QW-1]}}, dp[2]};
  end

  always_ff @(posedge clk) begin
    face <= !sum[SW-1] && (sum != '0);
    idx5 <= idx4;
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], in_valid};
    end
  end

  assign out_valid = vld[4];
  assign out_idx   = idx5;
  assign out_face  = face;
  assign active    = |vld;

endmodule

`default_nettype wire

[rtl/point_in_convex_hull_test.sv]
// point_in_convex_hull_test: vertex and triangle tables in block memories, query walker
// depends on pich_pkg and pich_datapath
//
//  port group                        dir  transfer
//  start/busy + kind..corner_c       in   start high and busy low at a rising edge
//  cfg_write + cfg_data              in   cfg_write high at a rising edge
//  done + outside, facing_triangle   out  done high for one cycle, always taken
//
// vertex and triangle writes leave busy low.
// a query holds busy while it walks n = min(triangle_count, MAX_TRIANGLES) triangles and
// ends early at the first facing one; the walk issues one triangle read per cycle, and
// each read passes through the two memory reads and the five stage half-space pipeline.
// the result shows with done in the cycle busy falls; a new item may be taken then.
// rst is synchronous and clears the control state and triangle_count; tables are unset.
`default_nettype none

module point_in_convex_hull_test #(
  parameter int MAX_VERTICES  = pich_pkg::DEF_MAX_VERTICES,
  parameter int MAX_TRIANGLES = pich_pkg::DEF_MAX_TRIANGLES,
  parameter int COORD_BITS    = pich_pkg::DEF_COORD_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [pich_pkg::KIND_W-1:0]       kind,
  input  wire logic [pich_pkg::SLOT_W-1:0]       slot,
  input  wire logic signed [COORD_BITS-1:0]      coord_x,
  input  wire logic signed [COORD_BITS-1:0]      coord_y,
  input  wire logic signed [COORD_BITS-1:0]      coord_z,
  input  wire logic [pich_pkg::CORNER_W-1:0]     corner_a,
  input  wire logic [pich_pkg::CORNER_W-1:0]     corner_b,
  input  wire logic [pich_pkg::CORNER_W-1:0]     corner_c,
  input  wire logic                              cfg_write,
  input  wire logic [pich_pkg::COUNT_W-1:0]      cfg_data,
  output logic                                   done,
  output logic                                   outside,
  output logic [pich_pkg::FACE_W-1:0]            facing_triangle
);
  import pich_pkg::*;

  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int TIDX_W = $clog2(MAX_TRIANGLES);
  localparam int CNT_W  = $clog2(MAX_TRIANGLES + 1);
  localparam int VW     = 3 * COORD_BITS;
  localparam int TW     = 3 * VIDX_W;

  logic [VW-1:0] vtx_a_mem [MAX_VERTICES];
  logic [VW-1:0] vtx_b_mem [MAX_VERTICES];
  logic [VW-1:0] vtx_c_mem [MAX_VERTICES];
  logic [TW-1:0] tri_mem   [MAX_TRIANGLES];

  state_t state, state_next;

  logic [COUNT_W-1:0] tri_count;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [CNT_W-1:0]   limit;
  logic [VW-1:0]      pnt;

  logic              accept;
  logic              vtx_we, tri_we;
  logic              issue;
  logic              finish;
  logic              hit;
  logic [TIDX_W-1:0] tri_raddr;
  logic [TW-1:0]     tri_rd;
  logic [VW-1:0]     va_rd, vb_rd, vc_rd;
  logic              s1_valid, s2_valid;
  logic [TIDX_W-1:0] s1_idx, s2_idx;

  logic              dp_valid, dp_face, dp_active;
  logic [TIDX_W-1:0] dp_idx;

  assign busy   = (state == ST_RUN);
  assign accept = start && !busy;

  always_comb begin
    vtx_we = 1'b0;
    tri_we = 1'b0;
    case (kind_t'(kind))
      KIND_VERTEX:   vtx_we = accept && (32'(slot) < MAX_VERTICES);
      KIND_TRIANGLE: tri_we = accept && (32'(slot) < MAX_TRIANGLES);
      KIND_QUERY:    ;
      default:       ;
    endcase
  end

  // table writes
  always_ff @(posedge clk) begin
    if (vtx_we) begin
      vtx_a_mem[VIDX_W'(slot)] <= {coord_z, coord_y, coord_x};
      vtx_b_mem[VIDX_W'(slot)] <= {coord_z, coord_y, coord_x};
      vtx_c_mem[VIDX_W'(slot)] <= {coord_z, coord_y, coord_x};
    end
    if (tri_we) begin
      tri_mem[TIDX_W'(slot)] <= {VIDX_W'(corner_reduce(corner_c, MAX_VERTICES)),
                                 VIDX_W'(corner_reduce(corner_b, MAX_VERTICES)),
                                 VIDX_W'(corner_reduce(corner_a, MAX_VERTICES))};
    end
  end

  // table reads: triangle, then its three corners
  assign tri_raddr = issue ? cnt[TIDX_W-1:0] : '0;

  always_ff @(posedge clk) begin
    tri_rd <= tri_mem[tri_raddr];
    va_rd  <= vtx_a_mem[tri_rd[VIDX_W-1:0]];
    vb_rd  <= vtx_b_mem[tri_rd[2*VIDX_W-1:VIDX_W]];
    vc_rd  <= vtx_c_mem[tri_rd[3*VIDX_W-1:2*VIDX_W]];
    s1_idx <= cnt[TIDX_W-1:0];
    s2_idx <= s1_idx;
  end

  pich_datapath #(
    .COORD_BITS (COORD_BITS),
    .IDX_W      (TIDX_W)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .flush     (finish),
    .in_valid  (s2_valid),
    .in_idx    (s2_idx),
    .vtx_a     (va_rd),
    .vtx_b     (vb_rd),
    .vtx_c     (vc_rd),
    .pnt       (pnt),
    .out_valid (dp_valid),
    .out_idx   (dp_idx),
    .out_face  (dp_face),
    .active    (dp_active)
  );

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    issue      = 1'b0;
    finish     = 1'b0;
    hit        = dp_valid && dp_face;
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (accept && (kind_t'(kind) == KIND_QUERY)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        issue = (cnt < limit);
        if (issue) begin
          cnt_next = cnt + 1'b1;
        end
        if (hit || (!issue && !s1_valid && !s2_valid && !dp_active)) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      tri_count <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      done      <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (cfg_write) begin
        tri_count <= cfg_data;
      end
      s1_valid <= issue && !finish;
      s2_valid <= s1_valid && !finish;
      done     <= finish;
    end
  end

  // query point and walk length, captured on the query transfer
  always_ff @(posedge clk) begin
    if (accept && (kind_t'(kind) == KIND_QUERY)) begin
      pnt   <= {coord_z, coord_y, coord_x};
      limit <= (32'(tri_count) > MAX_TRIANGLES) ? CNT_W'(MAX_TRIANGLES)
                                                : CNT_W'(tri_count);
    end
    if (finish) begin
      outside         <= hit;
      facing_triangle <= hit ? FACE_W'(dp_idx) : '0;
    end
  end

endmodule

`default_nettype wire

[sim/pich_checker.sv]
// pich_checker: watches item, register and result transfers of the point in hull test,
// predicts each query verdict from its own copy of the tables and compares the results
// depends on pich_pkg; instantiated by testbench beside the design
module pich_checker (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       start,
  input  logic                                       busy,
  input  logic [pich_pkg::KIND_W-1:0]                kind,
  input  logic [pich_pkg::SLOT_W-1:0]                slot,
  input  logic signed [pich_pkg::DEF_COORD_BITS-1:0] coord_x,
  input  logic signed [pich_pkg::DEF_COORD_BITS-1:0] coord_y,
  input  logic signed [pich_pkg::DEF_COORD_BITS-1:0] coord_z,
  input  logic [pich_pkg::CORNER_W-1:0]              corner_a,
  input  logic [pich_pkg::CORNER_W-1:0]              corner_b,
  input  logic [pich_pkg::CORNER_W-1:0]              corner_c,
  input  logic                                       cfg_write,
  input  logic [pich_pkg::COUNT_W-1:0]               cfg_data,
  input  logic                                       done,
  input  logic                                       outside,
  input  logic [pich_pkg::FACE_W-1:0]                facing_triangle,
  output int                                         failures,
  output int                                         waiting,
  output int                                         verdicts,
  output int                                         outside_hits
);
  timeunit 1ns;
  timeprecision 1ps;
  import pich_pkg::*;

  localparam int NV = DEF_MAX_VERTICES;
  localparam int NT = DEF_MAX_TRIANGLES;
  localparam int CB = DEF_COORD_BITS;

  typedef struct packed {
    logic [CORNER_W-1:0] a;
    logic [CORNER_W-1:0] b;
    logic [CORNER_W-1:0] c;
  } facet_t;

  typedef struct packed {
    logic              outside;
    logic [FACE_W-1:0] face;
  } verdict_t;

  logic signed [CB-1:0] vtx_x [NV];
  logic signed [CB-1:0] vtx_y [NV];
  logic signed [CB-1:0] vtx_z [NV];
  facet_t               facets [NT];
  logic [COUNT_W-1:0]   tri_limit;
  verdict_t             verdict_q [$];

  function automatic longint wide(input logic signed [CB-1:0] v);
    return v;
  endfunction

  // sign of dot(p - a, cross(b - a, c - a)), exact in 64 bits at 16-bit coordinates
  function automatic logic faces_point(input facet_t f, input longint px, input longint py,
                                       input longint pz);
    int     ia, ib, ic;
    longint ux, uy, uz, vx, vy, vz, nx, ny, nz;
    ia = int'(f.a) % NV;
    ib = int'(f.b) % NV;
    ic = int'(f.c) % NV;
    ux = wide(vtx_x[ib]) - wide(vtx_x[ia]);
    uy = wide(vtx_y[ib]) - wide(vtx_y[ia]);
    uz = wide(vtx_z[ib]) - wide(vtx_z[ia]);
    vx = wide(vtx_x[ic]) - wide(vtx_x[ia]);
    vy = wide(vtx_y[ic]) - wide(vtx_y[ia]);
    vz = wide(vtx_z[ic]) - wide(vtx_z[ia]);
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    return (px - wide(vtx_x[ia])) * nx + (py - wide(vtx_y[ia])) * ny
         + (pz - wide(vtx_z[ia])) * nz > 0;
  endfunction

  function automatic verdict_t hull_verdict(input longint px, input longint py,
                                            input longint pz);
    int       n;
    verdict_t v;
    n = (int'(tri_limit) > NT) ? NT : int'(tri_limit);
    v = '0;
    for (int i = 0; i < n; i++) begin
      if (faces_point(facets[i], px, py, pz)) begin
        v.outside = 1'b1;
        v.face = i[FACE_W-1:0];
        return v;
      end
    end
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      tri_limit = '0;
      verdict_q.delete();
    end else begin
      if ($isunknown(done)) begin
        $error("done is unknown");
        failures++;
      end
      if (done) begin
        if (verdict_q.size() == 0) begin
          $error("result transfer with no query waiting: outside %0b, facing_triangle %0d",
                 outside, facing_triangle);
          failures++;
        end else begin
          want = verdict_q.pop_front();
          verdicts++;
          if (want.outside) outside_hits++;
          if (outside !== want.outside) begin
            $error("outside: expected %0b, actual %0b", want.outside, outside);
            failures++;
          end
          if (facing_triangle !== want.face) begin
            $error("facing_triangle: expected %0d, actual %0d", want.face, facing_triangle);
            failures++;
          end
        end
      end
      if (cfg_write) tri_limit = cfg_data;
      if (start && !busy) begin
        case (kind_t'(kind))
          KIND_VERTEX: begin
            if (slot < NV) begin
              vtx_x[slot] = coord_x;
              vtx_y[slot] = coord_y;
              vtx_z[slot] = coord_z;
            end
          end
          KIND_TRIANGLE: begin
            if (slot < NT) facets[slot] = {corner_a, corner_b, corner_c};
          end
          KIND_QUERY: begin
            verdict_q = {verdict_q, hull_verdict(wide(coord_x), wide(coord_y), wide(coord_z))};
          end
          default: ;
        endcase
      end
    end
    waiting = verdict_q.size();
  end

endmodule

[sim/testbench.sv]
// testbench: clock, reset and stimulus for point_in_convex_hull_test; loads boxes as
// vertex and triangle tables, sends queries around them and gives the verdict
// depends on pich_pkg, point_in_convex_hull_test and pich_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pich_pkg::*;

  localparam int NV             = DEF_MAX_VERTICES;
  localparam int NT             = DEF_MAX_TRIANGLES;
  localparam int CB             = DEF_COORD_BITS;
  localparam int COORD_MAX      = (1 << (CB - 1)) - 1;
  localparam int COORD_MIN      = -(1 << (CB - 1));
  localparam int COUNT_MAX      = (1 << COUNT_W) - 1;
  localparam int ITEM_TARGET    = 1950;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int BOX_FACETS     = 12;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  // outward wound box faces, one octal digit per corner, corner bits are z y x
  localparam logic [BOX_FACETS*9-1:0] BOX_FACET_BITS = {
    9'o042, 9'o246, 9'o135, 9'o375, 9'o014, 9'o154,
    9'o263, 9'o367, 9'o021, 9'o123, 9'o456, 9'o576
  };

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [KIND_W-1:0]    kind;
  logic [SLOT_W-1:0]    slot;
  logic signed [CB-1:0] coord_x;
  logic signed [CB-1:0] coord_y;
  logic signed [CB-1:0] coord_z;
  logic [CORNER_W-1:0]  corner_a;
  logic [CORNER_W-1:0]  corner_b;
  logic [CORNER_W-1:0]  corner_c;
  logic                 cfg_write;
  logic [COUNT_W-1:0]   cfg_data;
  logic                 done;
  logic                 outside;
  logic [FACE_W-1:0]    facing_triangle;

  int failures, waiting, verdicts, outside_hits;
  int items_sent, queries_sent, boxes_loaded, gap_pct, quiet_cycles;

  point_in_convex_hull_test dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .slot(slot),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .done(done), .outside(outside), .facing_triangle(facing_triangle)
  );

  pich_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .slot(slot),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .done(done), .outside(outside), .facing_triangle(facing_triangle),
    .failures(failures), .waiting(waiting), .verdicts(verdicts), .outside_hits(outside_hits)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int clamp_coord(input int v);
    return v > COORD_MAX ? COORD_MAX : (v < COORD_MIN ? COORD_MIN : v);
  endfunction

  function automatic int axis_pick(input int mode, input int c, input int h);
    int sgn;
    sgn = $urandom_range(1) ? 1 : -1;
    case (mode)
      6: return clamp_coord(c + sgn * h * int'($urandom_range(1)));
      7: return clamp_coord(c + sgn * (h + int'($urandom_range(2)) - 1));
      8: return int'($urandom_range(65535)) + COORD_MIN;
      9: begin
        case ($urandom_range(2))
          0: return COORD_MIN;
          1: return COORD_MAX;
          default: return 0;
        endcase
      end
      default: return clamp_coord(c + int'($urandom_range(3 * h)) - (3 * h) / 2);
    endcase
  endfunction

  // one item transfer, with random sender gaps before it
  task automatic send_item(input logic [KIND_W-1:0] k, input int s, input int x, input int y,
                           input int z, input int a, input int b, input int c);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    kind <= k;
    slot <= s[SLOT_W-1:0];
    coord_x <= x[CB-1:0];
    coord_y <= y[CB-1:0];
    coord_z <= z[CB-1:0];
    corner_a <= a[CORNER_W-1:0];
    corner_b <= b[CORNER_W-1:0];
    corner_c <= c[CORNER_W-1:0];
    do @(posedge clk); while (busy);
    items_sent++;
    if (k == KIND_QUERY) queries_sent++;
  endtask

  // register write once the block has drained
  task automatic set_triangle_count(input int value);
    @(negedge clk);
    start <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value[COUNT_W-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_box(input int count_value);
    int         n, base, placed, nq, mode, cx, cy, cz, hx, hy, hz, a, b;
    logic [8:0] corners;
    n = count_value > NT ? NT : count_value;
    set_triangle_count(count_value);
    base = $urandom_range(NV - 8);
    cx = int'($urandom_range(40000)) - 20000;
    cy = int'($urandom_range(40000)) - 20000;
    cz = int'($urandom_range(40000)) - 20000;
    if ($urandom_range(3) == 0) begin
      hx = $urandom_range(1, 64);
      hy = $urandom_range(1, 64);
      hz = $urandom_range(1, 64);
    end else begin
      hx = $urandom_range(1, 12000);
      hy = $urandom_range(1, 12000);
      hz = $urandom_range(1, 12000);
    end
    for (int i = 0; i < 8; i++) begin
      send_item(KIND_VERTEX, base + i, i[0] ? cx + hx : cx - hx, i[1] ? cy + hy : cy - hy,
                i[2] ? cz + hz : cz - hz, $urandom, $urandom, $urandom);
    end
    // box faces spread over the slots in use; elsewhere zero-area triangles, now and then a random one
    placed = 0;
    for (int s = 0; s < n; s++) begin
      a = $urandom_range(7);
      b = $urandom_range(7);
      if (placed < BOX_FACETS && $urandom_range(n - s - 1) < BOX_FACETS - placed) begin
        corners = BOX_FACET_BITS[placed*9 +: 9];
        placed++;
      end else if ($urandom_range(15) == 0) begin
        corners = 9'($urandom);
      end else begin
        case ($urandom_range(2))
          0: corners = {a[2:0], a[2:0], b[2:0]};
          1: corners = {a[2:0], b[2:0], a[2:0]};
          default: corners = {b[2:0], a[2:0], a[2:0]};
        endcase
      end
      send_item(KIND_TRIANGLE, s, $urandom, $urandom, $urandom,
                base + corners[8:6], base + corners[5:3], base + corners[2:0]);
    end
    nq = $urandom_range(20, 45);
    for (int q = 0; q < nq; q++) begin
      if ($urandom_range(99) < 12) begin
        case ($urandom_range(7))
          0, 1, 2: send_item(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom);
          3, 4, 5: send_item(KIND_VERTEX, $urandom_range(NV, 127), $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom);
          6: begin
            if (n > 0) send_item(KIND_TRIANGLE, $urandom_range(n - 1), $urandom, $urandom,
                                 $urandom, base + $urandom_range(7), base + $urandom_range(7),
                                 base + $urandom_range(7));
          end
          default: send_item(KIND_VERTEX, base + $urandom_range(7), axis_pick(0, cx, hx),
                             axis_pick(0, cy, hy), axis_pick(0, cz, hz),
                             $urandom, $urandom, $urandom);
        endcase
      end
      mode = $urandom_range(9);
      send_item(KIND_QUERY, $urandom, axis_pick(mode, cx, hx), axis_pick(mode, cy, hy),
                axis_pick(mode, cz, hz), $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("FAIL point_in_convex_hull_test");
    $finish;
  end

  initial begin
    int count_value;
    rst = 1'b1;
    start = 1'b0;
    kind = KIND_VERTEX;
    slot = '0;
    coord_x = '0;
    coord_y = '0;
    coord_z = '0;
    corner_a = '0;
    corner_b = '0;
    corner_c = '0;
    cfg_write = 1'b0;
    cfg_data = '0;
    gap_pct = 38;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no triangles in use, then a tetrahedron at the coordinate extremes
    send_item(KIND_QUERY, 127, COORD_MIN, COORD_MAX, 0, 63, 63, 63);
    send_item(KIND_UNUSED, 5, 1, 2, 3, 4, 5, 6);
    send_item(KIND_VERTEX, 0, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0);
    send_item(KIND_VERTEX, 1, COORD_MAX, COORD_MIN, COORD_MIN, 63, 0, 0);
    send_item(KIND_VERTEX, 2, COORD_MIN, COORD_MAX, COORD_MIN, 0, 63, 0);
    send_item(KIND_VERTEX, 3, COORD_MIN, COORD_MIN, COORD_MAX, 0, 0, 63);
    send_item(KIND_VERTEX, NV, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0);
    send_item(KIND_VERTEX, 127, 0, 0, 0, 0, 0, 0);
    send_item(KIND_TRIANGLE, 0, COORD_MAX, COORD_MIN, 0, 0, 2, 1);
    send_item(KIND_TRIANGLE, 1, COORD_MIN, COORD_MAX, 0, 1, 1, 1);
    send_item(KIND_TRIANGLE, 2, 0, 0, 0, 0, 1, 3);
    send_item(KIND_TRIANGLE, 3, 0, 0, 0, 0, 3, 2);
    send_item(KIND_TRIANGLE, 4, 0, 0, 0, 1, 2, 3);
    set_triangle_count(5);
    send_item(KIND_QUERY, 0, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0);
    send_item(KIND_QUERY, 0, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0);
    send_item(KIND_QUERY, 0, COORD_MIN + 1, COORD_MIN + 1, COORD_MIN + 1, 0, 0, 0);
    send_item(KIND_QUERY, 0, 0, 0, COORD_MIN, 0, 0, 0);
    send_item(KIND_QUERY, 0, COORD_MIN, 0, 0, 0, 0, 0);
    send_item(KIND_QUERY, 0, COORD_MAX, COORD_MIN, COORD_MIN, 0, 0, 0);
    set_triangle_count(1);
    send_item(KIND_QUERY, 0, 0, 0, COORD_MIN, 0, 0, 0);
    send_item(KIND_QUERY, 0, 0, 0, COORD_MAX, 0, 0, 0);

    while (items_sent < ITEM_TARGET) begin
      gap_pct = items_sent < ITEM_TARGET / 3 ? 38 : (items_sent < 2 * ITEM_TARGET / 3 ? 47 : 0);
      case ($urandom_range(15))
        0: count_value = 0;
        1: count_value = $urandom_range(1, BOX_FACETS - 1);
        2: count_value = NT;
        3: count_value = COUNT_MAX;
        4: count_value = $urandom_range(NT + 1, COUNT_MAX - 1);
        default: count_value = $urandom_range(BOX_FACETS, 40);
      endcase
      load_box(count_value);
      boxes_loaded++;
    end

    @(negedge clk);
    start <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d item transfers: %0d queries over %0d loaded boxes",
             items_sent, queries_sent, boxes_loaded);
    $display("%0d verdicts checked, %0d of them outside, %0d mismatches",
             verdicts, outside_hits, failures);
    if (failures == 0) begin
      $display("PASS point_in_convex_hull_test");
    end else begin
      $display("FAIL point_in_convex_hull_test");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/pich_pkg.sv
rtl/pich_datapath.sv
rtl/point_in_convex_hull_test.sv
sim/pich_checker.sv
sim/testbench.sv
